@@ hw/rtl/display_command_list_framer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Display command list framer assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_COMMAND_LIST_FRAMER_TOP_DEFINES_SVH
`define DISPLAY_COMMAND_LIST_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DCLF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define DCLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dclf_pkg.sv @@
// ----------------------------------------------------------------------------
// dclf_pkg
// Types, opcode constants and the command length table for the framer.
// ----------------------------------------------------------------------------
package dclf_pkg;

    localparam int WORD_W      = 64;
    localparam int OPC_W       = 6;
    localparam int LEN_W       = 5;
    localparam int OPC_LO      = 56;
    localparam int OUT_TDATA_W = 72;  // word + opcode, padded to bytes

    localparam logic [OPC_W-1:0] FIRST_FWD_OPCODE = 6'd8;
    localparam logic [OPC_W-1:0] SYNC_FULL_OPCODE = 6'd41;
    localparam logic [OPC_W-1:0] OPC_PAIR_A       = 6'd36;
    localparam logic [OPC_W-1:0] OPC_PAIR_B       = 6'd37;
    localparam logic [2:0]       TRI_GROUP        = 3'd1;

    localparam logic [LEN_W-1:0] LEN_PAIR   = 5'd2;
    localparam logic [LEN_W-1:0] LEN_SINGLE = 5'd1;

    // Triangle command lengths, opcodes 8..15
    localparam logic [LEN_W-1:0] TRI_LEN [8] = '{
        5'd4, 5'd6, 5'd12, 5'd14, 5'd12, 5'd14, 5'd20, 5'd22
    };

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

    function automatic logic [LEN_W-1:0] cmd_len(input logic [OPC_W-1:0] op);
        logic [LEN_W-1:0] len;
        len = LEN_SINGLE;
        if (op[OPC_W-1:3] == TRI_GROUP) begin
            len = TRI_LEN[op[2:0]];
        end else begin
            case (op) inside
                OPC_PAIR_A, OPC_PAIR_B: len = LEN_PAIR;
                default:                len = LEN_SINGLE;
            endcase
        end
        return len;
    endfunction

endpackage

@@ hw/rtl/display_command_list_framer_top.sv @@
// ----------------------------------------------------------------------------
// display_command_list_framer_top
// Frames 64-bit display command words into whole commands and forwards
// commands with opcode 8 and up as tagged word runs.
//
//   channel | dir | carries
//   s_      | in  | tdata = command word
//   m_      | out | tdata = word, opcode; tlast = last word; tuser = sync irq
//
// Words are taken one per cycle while collecting. Once the last word of a
// forwarded command is in, input stalls while the store is replayed, one
// word per cycle through the registered read port. Dropped commands are
// taken without stalling the input and give no output. m_tready low holds
// the replay. Synchronous reset clears the sequencer; the word store is
// not cleared.
// ----------------------------------------------------------------------------
module display_command_list_framer_top import dclf_pkg::*; #(
    parameter int MAX_COMMAND_WORDS = 22
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WORD_W-1:0]      s_tdata,   // [63:0] command_word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [63:0] out_word, [69:64] out_opcode
    output logic                   m_tlast,   // last_word
    output logic                   m_tuser    // sync_interrupt
);

    localparam int ADDR_W = $clog2(MAX_COMMAND_WORDS);

    mem_cmd_t          mem_cmd;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    logic [OPC_W-1:0]  m_opcode;

    dclf_ctrl #(
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_word   (s_tdata),
        .mem_cmd  (mem_cmd),
        .waddr    (waddr),
        .raddr    (raddr),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_opcode (m_opcode),
        .m_last   (m_tlast),
        .m_sync   (m_tuser)
    );

    dclf_word_mem #(
        .DEPTH  (MAX_COMMAND_WORDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .mem_cmd (mem_cmd),
        .waddr   (waddr),
        .wdata   (s_tdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    assign m_tdata = {{(OUT_TDATA_W - WORD_W - OPC_W){1'b0}}, m_opcode, rdata};

endmodule

@@ hw/rtl/dclf_word_mem.sv @@
// ----------------------------------------------------------------------------
// dclf_word_mem
// Holding store for the words of one command; one write and one registered
// read port.
// ----------------------------------------------------------------------------
module dclf_word_mem import dclf_pkg::*; #(
    parameter int DEPTH  = 22,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  mem_cmd_t          mem_cmd,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while the output stage is stalled
    always_ff @(posedge aclk) begin
        if (mem_cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/dclf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dclf_ctrl
// Collect/emit sequencer: counts words into the store, decodes the command
// length and replays forwarded commands with per-word tags.
// ----------------------------------------------------------------------------
module dclf_ctrl import dclf_pkg::*; #(
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_word,
    output mem_cmd_t          mem_cmd,
    output logic [ADDR_W-1:0] waddr,
    output logic [ADDR_W-1:0] raddr,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OPC_W-1:0]  m_opcode,
    output logic              m_last,
    output logic              m_sync
);

    localparam int CNT_W = ADDR_W + 1;

    state_t            state_reg,  state_next;
    logic [ADDR_W-1:0] count_reg,  count_next;
    logic [OPC_W-1:0]  opcode_reg, opcode_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              valid_reg,  valid_next;
    logic [OPC_W-1:0]  out_op_reg;
    logic              out_last_reg;
    logic              out_sync_reg;

    logic [OPC_W-1:0]  cur_op;
    logic [LEN_W-1:0]  cur_len;
    logic              word_done;
    logic              rd_last;
    logic              advance;

    assign cur_op    = (count_reg == '0) ? s_word[OPC_LO +: OPC_W] : opcode_reg;
    assign cur_len   = cmd_len(cur_op);
    assign word_done = (CNT_W'(count_reg) + CNT_W'(1)) == CNT_W'(cur_len);
    assign rd_last   = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == CNT_W'(len_reg);
    assign advance   = !valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        opcode_next = opcode_reg;
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        valid_next  = valid_reg;
        mem_cmd     = '0;
        waddr       = count_reg;
        raddr       = rd_idx_reg;
        s_ready     = (state_reg == ST_COLLECT);

        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_COLLECT: begin
                if (s_valid) begin
                    mem_cmd.wr_en = 1'b1;
                    opcode_next   = cur_op;
                    if (word_done) begin
                        count_next = '0;
                        // low opcodes are consumed and dropped
                        if (cur_op >= FIRST_FWD_OPCODE) begin
                            state_next  = ST_EMIT;
                            len_next    = cur_len;
                            rd_idx_next = '0;
                        end
                    end else begin
                        count_next = count_reg + ADDR_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (advance) begin
                    mem_cmd.rd_en = 1'b1;
                    valid_next    = 1'b1;
                    rd_idx_next   = rd_idx_reg + ADDR_W'(1);
                    if (rd_last) begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_COLLECT;
            count_reg  <= '0;
            opcode_reg <= '0;
            rd_idx_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            opcode_reg <= opcode_next;
            rd_idx_reg <= rd_idx_next;
            valid_reg  <= valid_next;
        end
    end

    // tags ride alongside the registered memory read
    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        if (mem_cmd.rd_en) begin
            out_op_reg   <= opcode_reg;
            out_last_reg <= rd_last;
            out_sync_reg <= rd_last && (opcode_reg == SYNC_FULL_OPCODE);
        end
    end

    assign m_valid  = valid_reg;
    assign m_opcode = out_op_reg;
    assign m_last   = out_last_reg;
    assign m_sync   = out_sync_reg;

endmodule

@@ hw/rtl/dclf_checker.sv @@
// ----------------------------------------------------------------------------
// dclf_checker
// Port-level checks on the framer's output run and input stall behavior.
// ----------------------------------------------------------------------------
`include "display_command_list_framer_top_defines.svh"

module dclf_checker import dclf_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast,
    input logic                   m_tuser
);

    `DCLF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "output item changed while stalled")

    `DCLF_ASSERT_NOW(a_sync_on_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast,
        "sync flag on a non-final word")

    `DCLF_ASSERT_NOW(a_fwd_opcode, aclk, aresetn, m_tvalid,
        m_tdata[69:64] >= FIRST_FWD_OPCODE, "dropped opcode forwarded")

    `DCLF_ASSERT_NOW(a_mid_run_stall, aclk, aresetn, m_tvalid && !m_tlast, !s_tready,
        "input taken during a command replay")

endmodule

bind display_command_list_framer_top dclf_checker u_dclf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ tb/sv/display_command_list_framer_top_tb.sv @@
// ----------------------------------------------------------------------------
// display_command_list_framer_top_tb
// Streams display command words into the framer and checks every forwarded
// word, opcode, last marker and sync flag against an in-bench framing model.
// Directed commands cover the opcode extremes, pairs, sync and triangles;
// random commands follow, with bursty stalls on both channels.
// ----------------------------------------------------------------------------
module display_command_list_framer_top_tb;
    import dclf_pkg::*;

    localparam logic [OPC_W-1:0] OPC_LOWEST       = 6'd0;
    localparam logic [OPC_W-1:0] OPC_LAST_DROPPED = 6'd7;
    localparam logic [OPC_W-1:0] OPC_HIGHEST      = 6'd63;
    localparam logic [OPC_W-1:0] TRI_FIRST        = FIRST_FWD_OPCODE;
    localparam logic [OPC_W-1:0] TRI_LAST         = 6'd15;
    localparam int               WORD_TARGET      = 200;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [OPC_W-1:0]  opcode;
        logic              last;
        logic              irq;
    } fwd_word_t;

    class command_scoreboard;
        fwd_word_t         pending[$];
        logic [WORD_W-1:0] collected[$];
        logic [OPC_W-1:0]  cur_opcode;
        int                errors;

        function new();
            cur_opcode = '0;
            errors     = 0;
        endfunction

        static function int words_in(input logic [OPC_W-1:0] op);
            int tri_words [8] = '{4, 6, 12, 14, 12, 14, 20, 22};
            if (op >= TRI_FIRST && op <= TRI_LAST) return tri_words[op - TRI_FIRST];
            if (op == OPC_PAIR_A || op == OPC_PAIR_B) return 2;
            return 1;
        endfunction

        // Frame the accepted word; a completed forwarded command queues its run
        function void note_word(input logic [WORD_W-1:0] w);
            int        n;
            fwd_word_t e;
            if (collected.size() == 0) cur_opcode = w[OPC_LO +: OPC_W];
            collected.push_back(w);
            n = words_in(cur_opcode);
            if (collected.size() < n) return;
            if (cur_opcode >= FIRST_FWD_OPCODE) begin
                for (int i = 0; i < n; i++) begin
                    e.word   = collected[i];
                    e.opcode = cur_opcode;
                    e.last   = (i == n - 1);
                    e.irq    = (i == n - 1) && (cur_opcode == SYNC_FULL_OPCODE);
                    pending.push_back(e);
                end
            end
            collected.delete();
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] tdata,
                                   input logic tlast, input logic tuser);
            fwd_word_t e;
            if (pending.size() == 0) begin
                $error("unexpected result item: tdata %h tlast %b tuser %b",
                       tdata, tlast, tuser);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (tdata[WORD_W-1:0] !== e.word) begin
                $error("out_word: expected %h, got %h", e.word, tdata[WORD_W-1:0]);
                errors++;
            end
            if (tdata[WORD_W +: OPC_W] !== e.opcode) begin
                $error("out_opcode: expected %0d, got %0d", e.opcode, tdata[WORD_W +: OPC_W]);
                errors++;
            end
            if (tlast !== e.last) begin
                $error("last_word: expected %b, got %b", e.last, tlast);
                errors++;
            end
            if (tuser !== e.irq) begin
                $error("sync_interrupt: expected %b, got %b", e.irq, tuser);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [WORD_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    command_scoreboard sb = new();
    bit                tx_gaps_on = 1'b1;
    bit                rx_stalls_on = 1'b1;
    int                words_sent = 0;

    display_command_list_framer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Result side back-pressure
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Head word carries the opcode; tail words may carry a decoy opcode field
    task automatic send_command(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] fill,
                                input bit rand_body, input bit tag_tail,
                                input logic [OPC_W-1:0] tail_op);
        logic [WORD_W-1:0] w;
        int                n;
        n = command_scoreboard::words_in(op);
        for (int i = 0; i < n; i++) begin
            w = rand_body ? rand_word() : fill;
            if (i == 0) w[OPC_LO +: OPC_W] = op;
            else if (tag_tail) w[OPC_LO +: OPC_W] = tail_op;
            send_word(w);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [OPC_W-1:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return TRI_FIRST + OPC_W'($urandom_range(0, 7));
        if (r < 55) return $urandom_range(0, 1) ? OPC_PAIR_A : OPC_PAIR_B;
        if (r < 65) return SYNC_FULL_OPCODE;
        if (r < 80) return OPC_W'($urandom_range(0, OPC_LAST_DROPPED));
        return OPC_W'($urandom_range(0, OPC_HIGHEST));
    endfunction

    initial begin
        bit paused_mid;
        paused_mid = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        send_command(OPC_LOWEST, '0, 1'b0, 1'b0, OPC_LOWEST);
        send_command(OPC_LAST_DROPPED, '1, 1'b0, 1'b0, OPC_LOWEST);
        send_command(OPC_HIGHEST, '1, 1'b0, 1'b0, OPC_LOWEST);
        send_command(SYNC_FULL_OPCODE, '0, 1'b1, 1'b0, OPC_LOWEST);
        send_command(OPC_PAIR_A, '0, 1'b1, 1'b1, TRI_LAST);
        send_command(OPC_PAIR_B, '1, 1'b0, 1'b0, OPC_LOWEST);
        send_command(TRI_FIRST, '0, 1'b1, 1'b1, SYNC_FULL_OPCODE);
        send_command(TRI_FIRST + 6'd1, '0, 1'b1, 1'b0, OPC_LOWEST);
        drain_results();

        while (words_sent < WORD_TARGET) begin
            if (!paused_mid && words_sent >= WORD_TARGET / 2) begin
                paused_mid = 1'b1;
                drain_results();
            end
            if (words_sent >= WORD_TARGET * 4 / 5) begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            send_command(pick_opcode(), '0, 1'b1, $urandom_range(0, 3) == 0,
                         OPC_W'($urandom_range(0, OPC_HIGHEST)));
        end

        drain_results();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("display_command_list_framer_top_tb passed");
        end else begin
            $display("display_command_list_framer_top_tb failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("display_command_list_framer_top_tb failed");
        $finish;
    end

endmodule
